/* rtl/olc_pkg.sv */
// ----------------------------------------------------------------------------
// olc_pkg
// Shared types, codes and constants of the occupancy light controller.
// ----------------------------------------------------------------------------
package olc_pkg;

   // Ticks that make up one second, and the width of the sub-second counter
   localparam int unsigned TICKS_PER_SECOND = 1000;
   localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

   // Fixed field widths
   localparam int unsigned PRESS_W    = 12;
   localparam int unsigned SEC_W      = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [PRESS_W-1:0] PRESS_SAT = {PRESS_W{1'b1}};
   localparam logic [SEC_W-1:0]   SEC_SAT   = {SEC_W{1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_DELAY   = 3'd4;

   // Register reset values
   localparam logic [PRESS_W-1:0] SHORT_MIN_RST   = 12'd90;
   localparam logic [PRESS_W-1:0] SHORT_MAX_RST   = 12'd900;
   localparam logic [PRESS_W-1:0] LONG_MAX_RST    = 12'd3000;
   localparam logic [SEC_W-1:0]   OCC_TIMEOUT_RST = 16'd1800;
   localparam logic [SEC_W-1:0]   OFF_DELAY_RST   = 16'd30;

   // Remote action codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_ON   = 2'd1;
   localparam logic [1:0] ACT_OFF  = 2'd2;

   typedef enum logic [1:0] {
      MODE_OFF_AUTO  = 2'd0,
      MODE_ON_AUTO   = 2'd1,
      MODE_ON_HOLD   = 2'd2,
      MODE_OFF_DELAY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_ON   = 2'd1,
      CMD_OFF  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [PRESS_W-1:0] short_min;
      logic [PRESS_W-1:0] short_max;
      logic [PRESS_W-1:0] long_max;
      logic [SEC_W-1:0]   occ_timeout;
      logic [SEC_W-1:0]   off_delay;
   } olc_cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic               released;
      logic               handled;
      logic [PRESS_W-1:0] hold;
      logic               motion_seen;
      logic [SUB_W-1:0]   sub;
      logic [SEC_W-1:0]   elapsed;
   } olc_state_type;

   typedef struct packed {
      logic       button_pressed;
      logic       motion_level;
      logic [1:0] action;
   } olc_item_type;

   typedef struct packed {
      logic             lamp_on;
      mode_type         mode;
      logic             all_on;
      cmd_type          lamp_command;
      logic [SEC_W-1:0] remaining_s;
   } olc_result_type;

   localparam olc_state_type STATE_RST = '{
      mode:        MODE_OFF_AUTO,
      released:    1'b1,
      handled:     1'b0,
      hold:        '0,
      motion_seen: 1'b0,
      sub:         '0,
      elapsed:     '0
   };

endpackage

/* rtl/olc_req_if.sv */
// ----------------------------------------------------------------------------
// olc_req_if
// Tick channel: one word per millisecond tick with the sampled pins.
// ----------------------------------------------------------------------------
interface olc_req_if;
   logic       valid;
   logic       ready;
   logic       button_pressed;
   logic       motion_level;
   logic [1:0] action;

   modport source (output valid, output button_pressed, output motion_level,
                   output action, input ready);
   modport sink   (input valid, input button_pressed, input motion_level,
                   input action, output ready);
endinterface

/* rtl/olc_rsp_if.sv */
// ----------------------------------------------------------------------------
// olc_rsp_if
// Result channel: lamp state, send command and seconds remaining per tick.
// ----------------------------------------------------------------------------
interface olc_rsp_if;
   import olc_pkg::*;

   logic             valid;
   logic             ready;
   logic             lamp_on;
   logic [1:0]       mode;
   logic             all_on;
   logic [1:0]       lamp_command;
   logic [SEC_W-1:0] remaining_s;

   modport source (output valid, output lamp_on, output mode, output all_on,
                   output lamp_command, output remaining_s, input ready);
   modport sink   (input valid, input lamp_on, input mode, input all_on,
                   input lamp_command, input remaining_s, output ready);
endinterface

/* rtl/olc_step.sv */
// ----------------------------------------------------------------------------
// olc_step
// Next-state and result logic for one tick: seconds timer, remote command,
// button press timing, motion edge and timer expiry, in that order.
// ----------------------------------------------------------------------------
module olc_step (
   input  olc_pkg::olc_state_type  state,
   input  olc_pkg::olc_cfg_type    cfg,
   input  olc_pkg::olc_item_type   item,
   output olc_pkg::olc_state_type  state_next,
   output olc_pkg::olc_result_type result
);
   import olc_pkg::*;

   always_comb begin
      olc_state_type    s;
      cmd_type          cmd;
      logic [SEC_W-1:0] remaining;

      s         = state;
      cmd       = CMD_NONE;
      remaining = '0;

      // advance the seconds timer, saturating the seconds count
      if (s.sub == SUB_W'(TICKS_PER_SECOND - 1)) begin
         s.sub = '0;
         if (s.elapsed != SEC_SAT) begin
            s.elapsed = s.elapsed + 1'b1;
         end
      end else begin
         s.sub = s.sub + 1'b1;
      end

      // apply the remote command; unused code is dropped
      case (item.action)
         ACT_ON: begin
            s.mode    = MODE_ON_AUTO;
            s.sub     = '0;
            s.elapsed = '0;
            cmd       = CMD_ON;
         end
         ACT_OFF: begin
            s.mode = MODE_OFF_AUTO;
            cmd    = CMD_OFF;
         end
         default: ;
      endcase

      // time the button hold and classify it on release
      if (item.button_pressed && s.released) begin
         s.hold    = '0;
         s.handled = 1'b0;
      end else if (!s.released) begin
         if (s.hold != PRESS_SAT) begin
            s.hold = s.hold + 1'b1;
         end
         if (!item.button_pressed && !s.handled) begin
            if (s.hold >= cfg.short_min && s.hold <= cfg.short_max) begin
               if (s.mode == MODE_ON_AUTO || s.mode == MODE_ON_HOLD) begin
                  s.mode = MODE_OFF_DELAY;
                  cmd    = CMD_OFF;
               end else begin
                  s.mode = MODE_ON_AUTO;
                  cmd    = CMD_ON;
               end
               s.sub     = '0;
               s.elapsed = '0;
               s.handled = 1'b1;
            end else if (s.hold > cfg.short_max && s.hold <= cfg.long_max) begin
               if (s.mode == MODE_ON_AUTO) begin
                  s.mode = MODE_ON_HOLD;
                  cmd    = CMD_ON;
               end
               s.handled = 1'b1;
            end
         end
      end
      s.released = !item.button_pressed;

      // motion: rising edge turns on from off-auto, any motion restarts on-auto
      if (item.motion_level) begin
         if (!s.motion_seen) begin
            s.motion_seen = 1'b1;
            if (s.mode == MODE_OFF_AUTO) begin
               s.mode = MODE_ON_AUTO;
               cmd    = CMD_ON;
            end
         end
         if (s.mode == MODE_ON_AUTO) begin
            s.sub     = '0;
            s.elapsed = '0;
         end
      end else begin
         s.motion_seen = 1'b0;
      end

      // expire on-auto and off-delay
      if (s.mode == MODE_ON_AUTO && s.elapsed > cfg.occ_timeout) begin
         s.mode = MODE_OFF_AUTO;
         cmd    = CMD_OFF;
      end
      if (s.mode == MODE_OFF_DELAY && s.elapsed >= cfg.off_delay) begin
         s.mode = MODE_OFF_AUTO;
         cmd    = CMD_OFF;
      end

      // seconds left in the running countdown
      if (s.mode == MODE_ON_AUTO && s.elapsed <= cfg.occ_timeout) begin
         remaining = cfg.occ_timeout - s.elapsed;
      end else if (s.mode == MODE_OFF_DELAY && s.elapsed <= cfg.off_delay) begin
         remaining = cfg.off_delay - s.elapsed;
      end

      state_next          = s;
      result.lamp_on      = (s.mode == MODE_ON_AUTO) || (s.mode == MODE_ON_HOLD);
      result.mode         = s.mode;
      result.all_on       = (s.mode == MODE_ON_HOLD);
      result.lamp_command = cmd;
      result.remaining_s  = remaining;
   end

endmodule

/* rtl/occupancy_light_controller_core.sv */
// ----------------------------------------------------------------------------
// occupancy_light_controller_core
// Four-mode room lamp controller advanced by one millisecond tick per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one tick word: button level, motion level and a remote
//   action (tick only, remote on, remote off). rsp_chan returns one word per
//   tick: lamp on, mode, on-hold flag, the on/off send command and the
//   seconds left in the running countdown.
//   Five registers (press limits, occupancy timeout, off delay) are written
//   through csr_write_en / csr_index / csr_wdata; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   An accepted tick word is loaded into the input register; the step logic
//   output is then loaded into the result register once that register is
//   free. Throughput: one tick word per clock while rsp_chan.ready is high;
//   the lamp state feeds back through the combinational step logic.
//   Reset: registers return to their defaults, lamp off-auto, button
//   released, timers cleared; both pipeline registers empty.
//   Stall: while rsp_chan.ready is low the result word holds and one more
//   tick word is still taken into the input register; req_chan.ready then
//   drops until the result word is taken.
// ----------------------------------------------------------------------------
module occupancy_light_controller_core (
   input  logic                             clock,
   input  logic                             reset,
   olc_req_if.sink                          req_chan,
   olc_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [olc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [olc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import olc_pkg::*;

   olc_cfg_type    cfg_ff, cfg_in;
   olc_state_type  state_ff, state_in;
   olc_item_type   item_ff;
   olc_result_type result_ff, step_result;
   logic           in_valid_ff, in_valid_in;
   logic           out_valid_ff, out_valid_in;
   logic           advance;
   logic           accept;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SHORT_MIN:   cfg_in.short_min   = csr_wdata[PRESS_W-1:0];
            CSR_SHORT_MAX:   cfg_in.short_max   = csr_wdata[PRESS_W-1:0];
            CSR_LONG_MAX:    cfg_in.long_max    = csr_wdata[PRESS_W-1:0];
            CSR_OCC_TIMEOUT: cfg_in.occ_timeout = csr_wdata[SEC_W-1:0];
            CSR_OFF_DELAY:   cfg_in.off_delay   = csr_wdata[SEC_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the input register drains into the result register when free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   olc_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{short_min:   SHORT_MIN_RST,
                           short_max:   SHORT_MAX_RST,
                           long_max:    LONG_MAX_RST,
                           occ_timeout: OCC_TIMEOUT_RST,
                           off_delay:   OFF_DELAY_RST};
         state_ff     <= STATE_RST;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.button_pressed <= req_chan.button_pressed;
         item_ff.motion_level   <= req_chan.motion_level;
         item_ff.action         <= req_chan.action;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.lamp_on      = result_ff.lamp_on;
   assign rsp_chan.mode         = result_ff.mode;
   assign rsp_chan.all_on       = result_ff.all_on;
   assign rsp_chan.lamp_command = result_ff.lamp_command;
   assign rsp_chan.remaining_s  = result_ff.remaining_s;

   // a word moved out of the input register always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word did not reach the result register");

   // the sub-second counter never reaches a full second
   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.sub <= SUB_W'(TICKS_PER_SECOND - 1))
      else $error("sub-second counter out of range");

   // a countdown is shown only while one runs
   a_remaining_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.remaining_s != '0) |->
      (result_ff.mode == MODE_ON_AUTO || result_ff.mode == MODE_OFF_DELAY))
      else $error("remaining seconds outside a countdown mode");

   // on-hold always means the lamp is on
   a_all_on_lamp: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.all_on) |-> result_ff.lamp_on)
      else $error("on-hold without lamp on");

   // lamp state only changes when a word is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("lamp state changed without a tick");

endmodule

/* tb/sv/olc_lamp_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olc_lamp_scoreboard
// Watches the tick and result channels of the occupancy light controller,
// keeps its own copy of the lamp state and the registers, forecasts the
// result word of every accepted tick word and compares it in order with the
// words that the block returns.
// ----------------------------------------------------------------------------
module olc_lamp_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   olc_req_if                             req_tap,
   olc_rsp_if                             rsp_tap,
   input  logic                           csr_write_en,
   input  logic [olc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [olc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    awaited
);
   import olc_pkg::*;

   olc_cfg_type    lamp_cfg;
   olc_state_type  lamp_state;
   olc_result_type predicted_words[$];
   int unsigned    fails = 0;

   // Advance the lamp state by one tick and return the word it should give
   function automatic olc_result_type tick_lamp(input olc_item_type tick_word);
      olc_state_type      st;
      olc_result_type     word;
      cmd_type            cmd;
      logic [PRESS_W-1:0] press_len;
      logic [SEC_W-1:0]   left;
      st   = lamp_state;
      cmd  = CMD_NONE;
      left = '0;

      // seconds timer, saturating
      if (int'(st.sub) + 1 >= int'(TICKS_PER_SECOND)) begin
         st.sub = '0;
         if (st.elapsed != SEC_SAT) st.elapsed = st.elapsed + 1'b1;
      end else begin
         st.sub = st.sub + 1'b1;
      end

      // remote command; the spare code does nothing
      case (tick_word.action)
         ACT_ON: begin
            st.mode    = MODE_ON_AUTO;
            st.sub     = '0;
            st.elapsed = '0;
            cmd        = CMD_ON;
         end
         ACT_OFF: begin
            st.mode = MODE_OFF_AUTO;
            cmd     = CMD_OFF;
         end
         default: ;
      endcase

      // button: time the hold, classify it on release
      if (tick_word.button_pressed && !st.released) begin
         if (st.hold != PRESS_SAT) st.hold = st.hold + 1'b1;
      end else if (tick_word.button_pressed) begin
         st.hold    = '0;
         st.handled = 1'b0;
      end else if (!st.released) begin
         if (st.hold != PRESS_SAT) st.hold = st.hold + 1'b1;
         press_len = st.hold;
         if (press_len >= lamp_cfg.short_min && press_len <= lamp_cfg.short_max &&
             !st.handled) begin
            if (st.mode == MODE_ON_AUTO || st.mode == MODE_ON_HOLD) begin
               st.mode = MODE_OFF_DELAY;
               cmd     = CMD_OFF;
            end else begin
               st.mode = MODE_ON_AUTO;
               cmd     = CMD_ON;
            end
            st.sub     = '0;
            st.elapsed = '0;
            st.handled = 1'b1;
         end
         if (press_len > lamp_cfg.short_max && press_len <= lamp_cfg.long_max &&
             !st.handled) begin
            if (st.mode == MODE_ON_AUTO) begin
               st.mode = MODE_ON_HOLD;
               cmd     = CMD_ON;
            end
            st.handled = 1'b1;
         end
      end
      st.released = !tick_word.button_pressed;

      // motion: rising edge switches on from off-auto, level restarts on-auto
      if (tick_word.motion_level) begin
         if (!st.motion_seen) begin
            st.motion_seen = 1'b1;
            if (st.mode == MODE_OFF_AUTO) begin
               st.mode = MODE_ON_AUTO;
               cmd     = CMD_ON;
            end
         end
         if (st.mode == MODE_ON_AUTO) begin
            st.sub     = '0;
            st.elapsed = '0;
         end
      end else begin
         st.motion_seen = 1'b0;
      end

      // expiry of either countdown
      if (st.mode == MODE_ON_AUTO && st.elapsed > lamp_cfg.occ_timeout) begin
         st.mode = MODE_OFF_AUTO;
         cmd     = CMD_OFF;
      end
      if (st.mode == MODE_OFF_DELAY && st.elapsed >= lamp_cfg.off_delay) begin
         st.mode = MODE_OFF_AUTO;
         cmd     = CMD_OFF;
      end

      if (st.mode == MODE_ON_AUTO && st.elapsed <= lamp_cfg.occ_timeout)
         left = lamp_cfg.occ_timeout - st.elapsed;
      else if (st.mode == MODE_OFF_DELAY && st.elapsed <= lamp_cfg.off_delay)
         left = lamp_cfg.off_delay - st.elapsed;

      word.lamp_on      = (st.mode == MODE_ON_AUTO || st.mode == MODE_ON_HOLD);
      word.mode         = st.mode;
      word.all_on       = (st.mode == MODE_ON_HOLD);
      word.lamp_command = cmd;
      word.remaining_s  = left;
      lamp_state        = st;
      return word;
   endfunction

   // Track register writes, forecast accepted ticks, compare returned words
   always @(posedge clock) begin : watch
      olc_item_type   tick_word;
      olc_result_type want;
      if (reset) begin
         lamp_cfg.short_min   = SHORT_MIN_RST;
         lamp_cfg.short_max   = SHORT_MAX_RST;
         lamp_cfg.long_max    = LONG_MAX_RST;
         lamp_cfg.occ_timeout = OCC_TIMEOUT_RST;
         lamp_cfg.off_delay   = OFF_DELAY_RST;
         lamp_state           = STATE_RST;
         predicted_words.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SHORT_MIN:   lamp_cfg.short_min   = csr_wdata[PRESS_W-1:0];
               CSR_SHORT_MAX:   lamp_cfg.short_max   = csr_wdata[PRESS_W-1:0];
               CSR_LONG_MAX:    lamp_cfg.long_max    = csr_wdata[PRESS_W-1:0];
               CSR_OCC_TIMEOUT: lamp_cfg.occ_timeout = csr_wdata[SEC_W-1:0];
               CSR_OFF_DELAY:   lamp_cfg.off_delay   = csr_wdata[SEC_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tap.valid && rsp_tap.ready) begin
            if (predicted_words.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: result word with none outstanding: mode %0d cmd %0d rem %0d",
                           $realtime, rsp_tap.mode, rsp_tap.lamp_command, rsp_tap.remaining_s);
            end else begin
               want = predicted_words.pop_front();
               if (rsp_tap.lamp_on !== want.lamp_on || rsp_tap.mode !== 2'(want.mode) ||
                   rsp_tap.all_on !== want.all_on ||
                   rsp_tap.lamp_command !== 2'(want.lamp_command) ||
                   rsp_tap.remaining_s !== want.remaining_s) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: word mismatch (exp/got) lamp_on %0d/%0d mode %0d/%0d",
                               " all_on %0d/%0d cmd %0d/%0d rem %0d/%0d"},
                              $realtime, want.lamp_on, rsp_tap.lamp_on, want.mode,
                              rsp_tap.mode, want.all_on, rsp_tap.all_on, want.lamp_command,
                              rsp_tap.lamp_command, want.remaining_s, rsp_tap.remaining_s);
               end
            end
         end

         if (req_tap.valid && req_tap.ready) begin
            tick_word.button_pressed = req_tap.button_pressed;
            tick_word.motion_level   = req_tap.motion_level;
            tick_word.action         = req_tap.action;
            predicted_words.push_back(tick_lamp(tick_word));
         end
      end
      fail_count <= fails;
      awaited    <= predicted_words.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives millisecond tick words and register settings into the occupancy
// light controller: a directed pass over modes, presses and remote codes,
// then episodes of presses, motion, remote codes, noise and quiet runs under
// several register settings, with random gaps and stalls on both channels.
// The scoreboard beside the block does the checking.
// ----------------------------------------------------------------------------
module testbench;
   import olc_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam logic [1:0]  ACT_SPARE   = 2'd3;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;
   logic                  rsp_ready    = 1'b0;

   int unsigned mismatches;
   int unsigned awaited;
   int unsigned sent_ticks  = 0;
   int unsigned steady_left = 0;
   int unsigned cur_min, cur_max, cur_long;

   int unsigned rsp_hold    = 0;
   int unsigned rsp_taken   = 0;
   int unsigned sink_steady = 0;
   int unsigned quiet_cycles = 0;

   olc_req_if req_bus ();
   olc_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready;

   occupancy_light_controller_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   olc_lamp_scoreboard u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tap      (req_bus),
      .rsp_tap      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (mismatches),
      .awaited      (awaited)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result sink: random stalls, idle-free stretches and two long hold-offs
   always @(posedge clock) begin : result_sink
      logic        take;
      int unsigned roll;
      take = 1'b0;
      roll = $urandom_range(0, 99);
      if (reset) begin
         rsp_hold    <= 0;
         rsp_taken   <= 0;
         sink_steady <= 0;
      end else begin
         if (rsp_bus.valid && rsp_ready) rsp_taken <= rsp_taken + 1;
         if (rsp_bus.valid && rsp_ready && (rsp_taken + 1 == 600 || rsp_taken + 1 == 1200))
            rsp_hold <= 300;
         else if (rsp_hold != 0)
            rsp_hold <= rsp_hold - 1;
         else if (sink_steady != 0) begin
            sink_steady <= sink_steady - 1;
            take = 1'b1;
         end else if (roll < 2) begin
            sink_steady <= 200;
            take = 1'b1;
         end else if (roll < 62)
            take = 1'b1;
         else if (roll < 96)
            rsp_hold <= $urandom_range(0, 2);
         else
            rsp_hold <= $urandom_range(10, 40);
      end
      rsp_ready <= take;
   end

   // Watchdog: end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Offer one tick word after a random gap and hold it until taken
   task automatic send_tick(input logic press, input logic motion, input logic [1:0] act);
      int unsigned gap;
      int unsigned roll;
      gap = 0;
      if (steady_left != 0) begin
         steady_left--;
      end else begin
         roll = $urandom_range(0, 199);
         if (roll < 2) steady_left = 150;
         else if (roll < 110) gap = 0;
         else if (roll < 180) gap = $urandom_range(1, 3);
         else if (roll < 195) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 60);
      end
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.button_pressed <= press;
      req_bus.motion_level   <= motion;
      req_bus.action         <= act;
      do @(posedge clock); while (!req_bus.ready);
      sent_ticks++;
   endtask

   // Hold the button for len ticks (press tick plus len-1 held ticks), then release
   task automatic press_button(input int unsigned len, input logic motion, input logic mix);
      logic [1:0] act;
      send_tick(1'b1, motion, ACT_TICK);
      repeat (len - 1) begin
         act = (mix && $urandom_range(0, 49) == 0) ? 2'($urandom_range(0, 3)) : ACT_TICK;
         send_tick(1'b1, motion, act);
      end
      send_tick(1'b0, motion, ACT_TICK);
   endtask

   // Drop valid and wait until every forecast word has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // Load all five registers; call only while the block is idle
   task automatic apply_settings(input int unsigned smin, input int unsigned smax,
                                 input int unsigned lmax, input int unsigned tmo,
                                 input int unsigned dly);
      write_reg(CSR_SHORT_MIN, smin);
      write_reg(CSR_SHORT_MAX, smax);
      write_reg(CSR_LONG_MAX, lmax);
      write_reg(CSR_OCC_TIMEOUT, tmo);
      write_reg(CSR_OFF_DELAY, dly);
      csr_write_en <= 1'b0;
      cur_min  = smin;
      cur_max  = smax;
      cur_long = lmax;
   endtask

   // Random episodes until budget ticks are sent; drain once halfway through
   task automatic run_random(input int unsigned budget);
      int unsigned start;
      int unsigned kind;
      int unsigned len;
      int unsigned span;
      bit          paused;
      start  = sent_ticks;
      paused = 0;
      while (sent_ticks - start < budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // press lengths around the classification limits, or short ones
            case ($urandom_range(0, 9))
               0: len = cur_min - 1;
               1: len = cur_min;
               2: len = cur_max;
               3: len = cur_max + 1;
               4: len = cur_long;
               5: len = cur_long + 1;
               default: len = $urandom_range(1, (cur_long + 2 < 64) ? cur_long + 2 : 64);
            endcase
            // keep presses short so the tick count stays in range
            if (len == 0 || len > 64) len = $urandom_range(1, 64);
            press_button(len, 1'($urandom_range(0, 1)), 1'b1);
         end else if (kind < 55) begin
            repeat ($urandom_range(1, 20)) send_tick(1'b0, 1'b1, ACT_TICK);
            repeat ($urandom_range(1, 20)) send_tick(1'b0, 1'b0, ACT_TICK);
         end else if (kind < 65) begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 30))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
         end else begin
            // quiet run, now and then a longer one
            span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                : $urandom_range(60, 150);
            repeat (span) send_tick(1'b0, 1'b0, ACT_TICK);
         end
         if (!paused && sent_ticks - start >= budget / 2) begin
            settle();
            paused = 1;
         end
      end
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.button_pressed = 1'b0;
      req_bus.motion_level   = 1'b0;
      req_bus.action         = ACT_TICK;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass with short press limits and one-second countdowns
      apply_settings(3, 8, 15, 1, 1);
      send_tick(1'b0, 1'b0, ACT_TICK);
      send_tick(1'b0, 1'b0, ACT_SPARE);
      send_tick(1'b0, 1'b0, ACT_ON);
      send_tick(1'b0, 1'b0, ACT_OFF);
      send_tick(1'b0, 1'b1, ACT_TICK);
      send_tick(1'b0, 1'b1, ACT_TICK);
      send_tick(1'b0, 1'b0, ACT_TICK);
      press_button(2, 1'b0, 1'b0);
      press_button(3, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1, ACT_TICK);
      send_tick(1'b0, 1'b0, ACT_TICK);
      press_button(8, 1'b0, 1'b0);
      press_button(15, 1'b0, 1'b0);
      press_button(16, 1'b0, 1'b0);
      press_button(8, 1'b1, 1'b0);
      send_tick(1'b1, 1'b1, ACT_ON);
      send_tick(1'b0, 1'b0, ACT_OFF);
      run_random(150);

      // Narrowest regular press, long-press window up to the top
      settle();
      apply_settings(1, 1, 4095, 2, 1);
      send_tick(1'b0, 1'b0, ACT_ON);
      press_button(1, 1'b0, 1'b0);
      press_button(2, 1'b0, 1'b0);
      run_random(150);

      // All limits at their top: every short press is ignored
      settle();
      apply_settings(4095, 4095, 4095, 65535, 65535);
      run_random(100);

      // Zero countdowns: on-auto ends after one second, off-delay at once
      settle();
      apply_settings(2, 10, 30, 0, 0);
      send_tick(1'b0, 1'b0, ACT_ON);
      repeat (1010) send_tick(1'b0, 1'b0, ACT_TICK);
      send_tick(1'b0, 1'b0, ACT_ON);
      press_button(2, 1'b0, 1'b0);
      run_random(80);

      // Default press limits with short countdowns
      settle();
      apply_settings(90, 900, 3000, 1, 2);
      run_random(100);

      settle();
      if (mismatches == 0 && awaited == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
